// File: rtl/core/tlb_translate_fifo_lru_macros.svh
// Assertion macros shared by the TLB modules
`ifndef TLB_TRANSLATE_FIFO_LRU_MACROS_SVH
`define TLB_TRANSLATE_FIFO_LRU_MACROS_SVH

// Check that an antecedent implies a consequent on the next clock
`define TLB_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

// Check that a condition always holds
`define TLB_ASSERT_ALWAYS(label, clk_s, rst_s, cond, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) \
        else $error(msg);

`endif

// File: rtl/core/tlb_pkg.sv
// ----------------------------------------------------------------------------
// tlb_pkg
// Types, constants and command codes shared by the TLB modules.
// ----------------------------------------------------------------------------
package tlb_pkg;

    localparam int MAX_TLB_ENTRIES = 16;
    localparam int IDX_W = $clog2(MAX_TLB_ENTRIES);
    localparam int CNT_W = $clog2(MAX_TLB_ENTRIES + 1);

    localparam logic [1:0] CMD_TRANSLATE = 2'd0;
    localparam logic [1:0] CMD_FILL      = 2'd1;
    localparam logic [1:0] CMD_SWITCH    = 2'd2;
    localparam logic [1:0] CMD_NONE      = 2'd3;

    localparam logic [1:0] REG_PG_BYTES   = 2'd0;
    localparam logic [1:0] REG_PPT        = 2'd1;
    localparam logic [1:0] REG_ENTRIES    = 2'd2;
    localparam logic [1:0] REG_REPL_MODE  = 2'd3;

    localparam logic REPL_FIFO = 1'b0;
    localparam logic REPL_LRU  = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] logical_address;
        logic [31:0] frame_number;
        logic [15:0] process_id;
    } tlb_in_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] physical_address;
        logic [31:0] page_number;
        logic [31:0] first_level_index;
        logic [9:0]  second_level_index;
        logic        flushed;
    } tlb_out_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture transaction, start first divide
        logic div2_start;  // start page divide by the table size
        logic scan_start;  // reset entry scan
        logic scan_step;   // examine one entry
        logic commit;      // update table and output register
        logic mul_start;   // capture frame * page bytes
    } tlb_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_done;
        logic scan_done;
        logic is_switch;
    } tlb_sts_t;

endpackage

// File: rtl/core/tlb_div.sv
// ----------------------------------------------------------------------------
// tlb_div
// Radix-2 restoring divider, 32-bit dividend by 17-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module tlb_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [16:0] remainder
);
    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [17:0] trial;

    // Load the operands on start; otherwise shift one dividend bit into the partial remainder
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[31]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = 17'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[16:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = busy_reg && (cnt_reg == 6'd1);
    assign quotient  = quo_next;
    assign remainder = rem_next;
endmodule

// File: rtl/core/tlb_datapath.sv
// ----------------------------------------------------------------------------
// tlb_datapath
// Configuration, entry table, divider, entry scan and result register.
// ----------------------------------------------------------------------------
module tlb_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [16:0]         cfg_data,
    input  tlb_pkg::tlb_in_t    in_item,
    input  tlb_pkg::tlb_cmd_t   cmd,
    output tlb_pkg::tlb_sts_t   sts,
    output tlb_pkg::tlb_out_t   result
);
    import tlb_pkg::*;

    // Configuration registers
    logic [16:0] pgsz_reg;
    logic [10:0] ppt_reg;
    logic [4:0]  entries_reg;
    logic        mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pgsz_reg    <= 17'd64;
            ppt_reg     <= 11'd4;
            entries_reg <= 5'd4;
            mode_reg    <= REPL_FIFO;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PG_BYTES:  pgsz_reg    <= cfg_data;
                REG_PPT:       ppt_reg     <= cfg_data[10:0];
                REG_ENTRIES:   entries_reg <= cfg_data[4:0];
                REG_REPL_MODE: mode_reg    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Clamp configuration to legal ranges
    logic [16:0] ps_eff;
    logic [10:0] ppt_eff;
    logic [CNT_W-1:0] used_eff;
    always_comb
    begin
        ps_eff = pgsz_reg;
        if (pgsz_reg == 17'd0)
            ps_eff = 17'd1;
        else if (pgsz_reg > 17'd65536)
            ps_eff = 17'd65536;
        ppt_eff = ppt_reg;
        if (ppt_reg == 11'd0)
            ppt_eff = 11'd1;
        else if (ppt_reg > 11'd1024)
            ppt_eff = 11'd1024;
        if (entries_reg == 5'd0)
            used_eff = CNT_W'(1);
        else if (entries_reg > 5'(MAX_TLB_ENTRIES))
            used_eff = CNT_W'(MAX_TLB_ENTRIES);
        else
            used_eff = CNT_W'(entries_reg);
    end

    // Transaction capture
    tlb_in_t in_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= in_item;
    end

    // Divide results: page and offset, then the indices
    logic [31:0] page_reg, off_reg, fli_reg;
    logic [9:0]  sli_reg;
    logic        phase_reg;

    // Shared divider
    logic        div_start, div_done;
    logic [31:0] div_dividend, div_q;
    logic [16:0] div_divisor, div_r;
    assign div_start    = cmd.load || cmd.div2_start;
    assign div_dividend = cmd.load ? in_item.logical_address : page_reg;
    assign div_divisor  = cmd.load ? ps_eff : {6'd0, ppt_eff};

    tlb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Capture divide results in order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= 1'b0;
        else if (cmd.load)
            phase_reg <= 1'b0;
        else if (div_done)
            phase_reg <= 1'b1;
    end
    always_ff @(posedge clk)
    begin
        if (div_done && !phase_reg)
        begin
            page_reg <= div_q;
            off_reg  <= {15'd0, div_r};
        end
        else if (div_done)
        begin
            fli_reg <= div_q;
            sli_reg <= div_r[9:0];
        end
    end

    // Entry table
    logic [31:0] entry_page  [MAX_TLB_ENTRIES];
    logic [31:0] entry_frame [MAX_TLB_ENTRIES];
    logic [31:0] entry_stamp [MAX_TLB_ENTRIES];
    logic [CNT_W-1:0] fill_count_reg;
    logic [IDX_W-1:0] fifo_ptr_reg;
    logic [31:0]      clock_reg;
    logic [15:0]      cur_proc_reg;

    // Scan: find a match and the oldest stamp, one entry a cycle
    logic [CNT_W-1:0] scan_reg;
    logic             found_reg;
    logic [IDX_W-1:0] match_reg, lru_reg;
    logic [31:0]      lru_stamp_reg;
    logic [IDX_W-1:0] scan_idx;
    assign scan_idx = scan_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            scan_reg  <= '0;
            found_reg <= 1'b0;
            match_reg <= '0;
            lru_reg   <= '0;
        end
        else if (cmd.scan_step && scan_reg < fill_count_reg)
        begin
            if (!found_reg && entry_page[scan_idx] == page_reg)
            begin
                found_reg <= 1'b1;
                match_reg <= scan_idx;
            end
            if (scan_reg == '0 || entry_stamp[scan_idx] < lru_stamp_reg)
            begin
                lru_reg       <= scan_idx;
                lru_stamp_reg <= entry_stamp[scan_idx];
            end
            scan_reg <= scan_reg + CNT_W'(1);
        end
    end

    // Frame times page bytes, registered before the add
    logic [31:0] frame_sel, prod_reg;
    assign frame_sel = (in_reg.command == CMD_FILL) ? in_reg.frame_number
                                                    : entry_frame[match_reg];
    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
            prod_reg <= 32'(frame_sel * {15'd0, ps_eff});
    end

    // Slot choice for a fill
    logic [IDX_W-1:0] fifo_v, slot;
    logic             append;
    always_comb
    begin
        fifo_v = (CNT_W'(fifo_ptr_reg) < fill_count_reg) ? fifo_ptr_reg : '0;
        append = 1'b0;
        if (found_reg)
            slot = match_reg;
        else if (fill_count_reg < used_eff)
        begin
            slot   = fill_count_reg[IDX_W-1:0];
            append = 1'b1;
        end
        else if (mode_reg == REPL_LRU)
            slot = lru_reg;
        else
            slot = fifo_v;
    end

    logic [CNT_W-1:0] fifo_inc;
    assign fifo_inc = CNT_W'(fifo_v) + CNT_W'(1);

    // Reduce the next FIFO pointer modulo the entries in use during the scan
    logic [CNT_W-1:0] fmod_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
            fmod_reg <= fifo_inc;
        else if (cmd.scan_step && fmod_reg >= used_eff)
            fmod_reg <= fmod_reg - used_eff;
    end

    // Commit the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            fifo_ptr_reg   <= '0;
            clock_reg      <= '0;
            cur_proc_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            unique case (in_reg.command)
                CMD_TRANSLATE:
                    if (found_reg)
                        clock_reg <= clock_reg + 32'd1;
                CMD_FILL:
                begin
                    clock_reg <= clock_reg + 32'd1;
                    if (append)
                        fill_count_reg <= fill_count_reg + CNT_W'(1);
                    else if (!found_reg && mode_reg == REPL_FIFO)
                        fifo_ptr_reg <= fmod_reg[IDX_W-1:0];
                end
                CMD_SWITCH:
                begin
                    if (cur_proc_reg != in_reg.process_id)
                        fill_count_reg <= '0;
                    cur_proc_reg <= in_reg.process_id;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (in_reg.command == CMD_TRANSLATE && found_reg)
                entry_stamp[match_reg] <= clock_reg;
            else if (in_reg.command == CMD_FILL)
            begin
                entry_page[slot]  <= page_reg;
                entry_frame[slot] <= in_reg.frame_number;
                entry_stamp[slot] <= clock_reg;
            end
        end
    end

    // Result register
    tlb_out_t res_reg, res_next;
    always_comb
    begin
        res_next = '0;
        unique case (in_reg.command)
            CMD_TRANSLATE, CMD_FILL:
            begin
                res_next.hit = found_reg || (in_reg.command == CMD_FILL);
                res_next.physical_address =
                    (found_reg || in_reg.command == CMD_FILL) ? off_reg + prod_reg
                                                              : 32'd0;
                res_next.page_number        = page_reg;
                res_next.first_level_index  = fli_reg;
                res_next.second_level_index = sli_reg;
            end
            CMD_SWITCH:
                res_next.flushed = (cur_proc_reg != in_reg.process_id);
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            res_reg <= res_next;
    end

    assign result         = res_reg;
    assign sts.div_done   = div_done;
    assign sts.scan_done  = (scan_reg >= fill_count_reg);
    assign sts.is_switch  = (in_reg.command != CMD_TRANSLATE)
                            && (in_reg.command != CMD_FILL);

`include "tlb_translate_fifo_lru_macros.svh"
    `TLB_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_count_reg <= CNT_W'(MAX_TLB_ENTRIES), "fill count over depth")
    `TLB_ASSERT_NEXT(a_sw_flush, clk, rst_n, cmd.commit && in_reg.command == CMD_SWITCH && cur_proc_reg != in_reg.process_id, fill_count_reg == '0, "switch did not flush")
    `TLB_ASSERT_NEXT(a_clk_step, clk, rst_n, cmd.commit && in_reg.command == CMD_FILL, clock_reg == $past(clock_reg) + 32'd1, "stamp clock did not advance")
endmodule

// File: rtl/core/tlb_ctrl.sv
// ----------------------------------------------------------------------------
// tlb_ctrl
// Sequencer: two divides, entry scan, multiply, commit; a switch or unused command goes straight to commit.
// ----------------------------------------------------------------------------
module tlb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tlb_pkg::tlb_sts_t sts,
    output tlb_pkg::tlb_cmd_t cmd,
    output logic              busy,
    output logic              done
);
    import tlb_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DIV1   = 8'b0000_0010,
        ST_DIV2   = 8'b0000_0100,
        ST_SCAN   = 8'b0000_1000,
        ST_MUL    = 8'b0001_0000,
        ST_COMMIT = 8'b0010_0000,
        ST_DONE   = 8'b0100_0000,
        ST_SWITCH = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Advance through the phases of one transaction
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV1;
                end
            ST_DIV1:
                if (sts.is_switch)
                    state_next = ST_SWITCH;
                else if (sts.div_done)
                begin
                    state_next = ST_DIV2;
                end
            ST_DIV2:
            begin
                cmd.div2_start = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done && sts.div_done)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_COMMIT;
            end
            ST_COMMIT, ST_SWITCH:
            begin
                cmd.commit = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

`include "tlb_translate_fifo_lru_macros.svh"
    `TLB_ASSERT_NEXT(a_commit_done, clk, rst_n, cmd.commit, state_reg == ST_DONE, "commit not followed by done")
    `TLB_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "start not taken")
    `TLB_ASSERT_ALWAYS(a_state_onehot, clk, rst_n, $onehot(state_reg), "state not one-hot")
endmodule

// File: rtl/core/tlb_translate_fifo_lru.sv
// ----------------------------------------------------------------------------
// tlb_translate_fifo_lru
// TLB with address split and FIFO or LRU replacement.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  command   start / busy       cmd_in  (tlb_in_t)
//  result    valid (1 cycle)    result  (tlb_out_t)
//  config    cfg_we             cfg_index, cfg_data
//
// A translate or fill keeps busy high from the accepting edge while it runs
// the shared serial divider (page and offset), starts the second divide, runs
// it (indices) with the entry scan alongside, then multiplies, commits and
// gives the result; the next command is taken in the cycle after the result.
// A process switch or unused command skips the divides, scan and multiply.
// Reset clears control state; the receiver cannot stall.
// ----------------------------------------------------------------------------
module tlb_translate_fifo_lru (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tlb_pkg::tlb_in_t  cmd_in,
    output logic              valid,
    output tlb_pkg::tlb_out_t result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [16:0]       cfg_data
);
    import tlb_pkg::*;

    tlb_cmd_t ctl_cmd;
    tlb_sts_t dp_sts;

    tlb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (dp_sts),
        .cmd   (ctl_cmd),
        .busy  (busy),
        .done  (valid)
    );

    tlb_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (cmd_in),
        .cmd       (ctl_cmd),
        .sts       (dp_sts),
        .result    (result)
    );
endmodule

// File: test/tlb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlb_checker
// Watches the command, configuration and result channels of the TLB,
// predicts each result from a private copy of the table state and
// compares every returned transaction field by field.
// ----------------------------------------------------------------------------
module tlb_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  tlb_pkg::tlb_in_t  cmd_in,
    input  logic              valid,
    input  tlb_pkg::tlb_out_t result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [16:0]       cfg_data,
    output int                errors,
    output int                pending
);
    import tlb_pkg::*;

    // Shadow table and control state
    logic [31:0] shadow_page  [MAX_TLB_ENTRIES];
    logic [31:0] shadow_frame [MAX_TLB_ENTRIES];
    logic [31:0] shadow_stamp [MAX_TLB_ENTRIES];
    logic [4:0]  valid_count;
    logic [3:0]  replace_ptr;
    logic [31:0] stamp_clock;
    logic [15:0] active_pid;

    // Shadow configuration registers
    logic [16:0] page_bytes;
    logic [10:0] table_pages;
    logic [4:0]  entries_used;
    logic        repl_mode;

    tlb_out_t expected_results [$];

    // Compute the result of one command and advance the shadow state
    task automatic predict_translation(input tlb_in_t item);
        logic [31:0] ps, ppt, used, page, off, slot;
        int          found;
        tlb_out_t    res;
        begin
            ps   = (page_bytes == 0) ? 32'd1 : (page_bytes > 17'd65536) ? 32'd65536
                 : 32'(page_bytes);
            ppt  = (table_pages == 0) ? 32'd1 : (table_pages > 11'd1024) ? 32'd1024
                 : 32'(table_pages);
            used = (entries_used == 0) ? 32'd1
                 : (entries_used > MAX_TLB_ENTRIES) ? 32'(MAX_TLB_ENTRIES)
                 : 32'(entries_used);
            page = item.logical_address / ps;
            off  = item.logical_address % ps;
            res  = '0;
            found = -1;
            if (item.command == CMD_TRANSLATE || item.command == CMD_FILL)
            begin
                for (int i = 0; i < valid_count && i < MAX_TLB_ENTRIES; i++)
                    if (found < 0 && shadow_page[i] == page) found = i;
                if (item.command == CMD_TRANSLATE)
                begin
                    if (found >= 0)
                    begin
                        shadow_stamp[found] = stamp_clock;
                        stamp_clock = stamp_clock + 32'd1;
                        res.hit = 1'b1;
                        res.physical_address = off + shadow_frame[found] * ps;
                    end
                end
                else
                begin
                    if (found >= 0)
                        slot = 32'(found);
                    else if (32'(valid_count) < used)
                    begin
                        slot = 32'(valid_count);
                        valid_count = valid_count + 5'd1;
                    end
                    else if (repl_mode == REPL_LRU)
                    begin
                        slot = 32'd0;
                        for (int i = 1; i < valid_count && i < MAX_TLB_ENTRIES; i++)
                            if (shadow_stamp[i] < shadow_stamp[slot]) slot = 32'(i);
                    end
                    else
                    begin
                        slot = (replace_ptr < valid_count) ? 32'(replace_ptr) : 32'd0;
                        replace_ptr = 4'((slot + 32'd1) % used);
                    end
                    if (slot >= MAX_TLB_ENTRIES) slot = 32'd0;
                    shadow_page[slot]  = page;
                    shadow_frame[slot] = item.frame_number;
                    shadow_stamp[slot] = stamp_clock;
                    stamp_clock = stamp_clock + 32'd1;
                    res.hit = 1'b1;
                    res.physical_address = off + item.frame_number * ps;
                end
                res.page_number        = page;
                res.first_level_index  = page / ppt;
                res.second_level_index = 10'(page % ppt);
            end
            else if (item.command == CMD_SWITCH)
            begin
                if (active_pid != item.process_id)
                begin
                    valid_count = '0;
                    res.flushed = 1'b1;
                end
                active_pid = item.process_id;
            end
            expected_results.push_back(res);
        end
    endtask

    task automatic note_field(input string field, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
        begin
            if (exp_v !== act_v)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t mismatch %s: expected %h, got %h",
                             $realtime, field, exp_v, act_v);
            end
        end
    endtask

    // Track transactions at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        tlb_out_t exp_r;
        if (!rst_n)
        begin
            valid_count  = '0;
            replace_ptr  = '0;
            stamp_clock  = '0;
            active_pid   = '0;
            page_bytes   = 17'd64;
            table_pages  = 11'd4;
            entries_used = 5'd4;
            repl_mode    = REPL_FIFO;
            errors       = 0;
            expected_results.delete();
            pending      = 0;
        end
        else
        begin
            if (valid)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t unexpected result %h", $realtime, result);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    note_field("hit", 32'(exp_r.hit), 32'(result.hit));
                    note_field("physical_address", exp_r.physical_address,
                               result.physical_address);
                    note_field("page_number", exp_r.page_number, result.page_number);
                    note_field("first_level_index", exp_r.first_level_index,
                               result.first_level_index);
                    note_field("second_level_index", 32'(exp_r.second_level_index),
                               32'(result.second_level_index));
                    note_field("flushed", 32'(exp_r.flushed), 32'(result.flushed));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PG_BYTES:  page_bytes   = cfg_data;
                    REG_PPT:       table_pages  = cfg_data[10:0];
                    REG_ENTRIES:   entries_used = cfg_data[4:0];
                    REG_REPL_MODE: repl_mode    = cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy)
                predict_translation(cmd_in);
            pending = expected_results.size();
        end
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the TLB through directed and random command streams under several
// register settings, with random gaps between commands; a checker module
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import tlb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    tlb_in_t     cmd_in;
    logic        valid;
    tlb_out_t    result;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;
    int          errors;
    int          pending;

    // Stimulus-side view of the page bytes and a pool of pages to reuse
    logic [31:0] cur_pg_bytes;
    logic [31:0] page_pool [24];
    bit          quiet_phase;

    tlb_translate_fifo_lru u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd_in    (cmd_in),
        .valid     (valid),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tlb_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd_in    (cmd_in),
        .valid     (valid),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hold a command until accepted, then idle for a random gap
    task automatic issue(input tlb_in_t item);
        int gap;
        begin
            start  <= 1'b1;
            cmd_in <= item;
            do @(posedge clk); while (busy);
            gap = 0;
            if (!quiet_phase)
            begin
                case ($urandom_range(0, 19))
                    0:       gap = $urandom_range(20, 90);
                    1, 2, 3, 4, 5: gap = $urandom_range(1, 4);
                    default: gap = 0;
                endcase
            end
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Write one register once the block has drained
    task automatic write_reg(input logic [1:0] idx, input logic [16:0] data);
        begin
            start <= 1'b0;
            wait (pending == 0);
            repeat (80) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic configure(input logic [16:0] ps, input logic [10:0] ppt,
                             input logic [4:0] ents, input logic mode);
        logic [63:0] span;
        begin
            write_reg(REG_PG_BYTES, ps);
            write_reg(REG_PPT, 17'(ppt));
            write_reg(REG_ENTRIES, 17'(ents));
            write_reg(REG_REPL_MODE, 17'(mode));
            cur_pg_bytes = (ps == 0) ? 32'd1 : (ps > 17'd65536) ? 32'd65536 : 32'(ps);
            span = 64'h1_0000_0000 / 64'(cur_pg_bytes);
            foreach (page_pool[i])
                page_pool[i] = 32'({$urandom, $urandom} % span);
        end
    endtask

    function automatic tlb_in_t make_item(input logic [1:0] cmd, input logic [31:0] page,
                                          input logic [31:0] frame);
        tlb_in_t it;
        begin
            it.command = cmd;
            it.logical_address = page * cur_pg_bytes
                               + 32'($urandom_range(0, cur_pg_bytes - 1));
            it.frame_number = frame;
            it.process_id = 16'($urandom);
            return it;
        end
    endfunction

    // Mostly fills and lookups on a small page pool, some switches and noise
    task automatic random_run(input int count);
        tlb_in_t it;
        int      pick;
        begin
            for (int n = 0; n < count; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    it = make_item(CMD_TRANSLATE, page_pool[$urandom_range(0, 23)], $urandom);
                else if (pick < 80)
                    it = make_item(CMD_FILL, page_pool[$urandom_range(0, 23)], $urandom);
                else if (pick < 87)
                begin
                    it = make_item(CMD_SWITCH, 32'd0, $urandom);
                    it.process_id = 16'($urandom_range(0, 2));
                end
                else if (pick < 90)
                    it = make_item(CMD_NONE, 32'd0, $urandom);
                else
                begin
                    it.logical_address = $urandom;
                    it.frame_number    = $urandom;
                    it.process_id      = 16'($urandom);
                    it.command         = 2'($urandom_range(0, 2));
                end
                issue(it);
                quiet_phase = (n % 60) < 15;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd_in    = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_PG_BYTES;
        cfg_data  = '0;
        quiet_phase = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every command, re-fill, switch without and with flush
        configure(17'd64, 11'd4, 5'd4, REPL_FIFO);
        issue('{CMD_TRANSLATE, 32'h0, 32'h0, 16'h0});
        issue('{CMD_TRANSLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF});
        issue('{CMD_FILL, 32'h0000_1040, 32'hFFFF_FFFF, 16'h0});
        issue('{CMD_TRANSLATE, 32'h0000_107F, 32'h0, 16'h0});
        issue('{CMD_FILL, 32'h0000_1041, 32'h0000_0123, 16'h0});
        issue('{CMD_TRANSLATE, 32'h0000_1000, 32'h0, 16'h0});
        issue('{CMD_FILL, 32'hFFFF_FFFF, 32'h0, 16'h0});
        issue('{CMD_FILL, 32'h0000_0000, 32'h0000_0007, 16'h0});
        issue('{CMD_FILL, 32'h0000_2000, 32'h0000_0008, 16'h0});
        issue('{CMD_FILL, 32'h0000_3000, 32'h0000_0009, 16'h0});
        issue('{CMD_TRANSLATE, 32'h0000_1040, 32'h0, 16'h0});
        issue('{CMD_SWITCH, 32'h0, 32'h0, 16'h0000});
        issue('{CMD_TRANSLATE, 32'h0000_3000, 32'h0, 16'h0});
        issue('{CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF});
        issue('{CMD_SWITCH, 32'h0, 32'h0, 16'hFFFF});
        issue('{CMD_TRANSLATE, 32'h0000_3000, 32'h0, 16'h0});

        // Lowered entry count below the filled count
        configure(17'd64, 11'd4, 5'd16, REPL_LRU);
        random_run(60);
        configure(17'd4096, 11'd1024, 5'd3, REPL_FIFO);
        random_run(60);

        // Extremes and out-of-range register values
        configure(17'd1, 11'd1, 5'd1, REPL_LRU);
        random_run(50);
        configure(17'd65536, 11'd1024, 5'd16, REPL_FIFO);
        random_run(60);
        configure(17'd0, 11'd0, 5'd0, REPL_FIFO);
        random_run(40);
        configure(17'h1FFFF, 11'h7FF, 5'h1F, REPL_LRU);
        random_run(60);

        // Random settings
        for (int p = 0; p < 5; p++)
        begin
            configure(17'($urandom_range(1, 300)), 11'($urandom_range(1, 1024)),
                      5'($urandom_range(1, 16)), 1'($urandom));
            random_run(45);
        end

        start <= 1'b0;
        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tlb_translate_fifo_lru verification clean");
        else
            $display("tlb_translate_fifo_lru verification failed");
        $finish;
    end

    // Hard stop on a hang
    initial
    begin
        #30ms;
        $display("tlb_translate_fifo_lru verification failed");
        $finish;
    end

endmodule
